### design/alr_pkg.sv
// shared word types and constants for the address literal recognizer
package alr_pkg;

  // result classes
  typedef enum logic [2:0] {
    KIND_INVALID = 3'd0,
    KIND_MAC     = 3'd1,
    KIND_IPV6    = 3'd2,
    KIND_IPV4    = 3'd3,
    KIND_NUMBER  = 3'd4,
    KIND_NAME    = 3'd5
  } kind_t;

  // one character of a word
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } alr_in_t;

  // one classified word
  typedef struct packed {
    kind_t       kind;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } alr_out_t;

  localparam logic [4:0]  MAC_TEXT_LEN = 5'd17;
  localparam logic [4:0]  LEN_MAX      = 5'd31;
  localparam logic [3:0]  GROUP_SLOTS  = 4'd8;
  localparam logic [3:0]  DBL_GROUPS   = 4'd7;
  localparam logic [2:0]  GROUP_DIGITS = 3'd4;
  localparam logic [2:0]  OCTET_LAST   = 3'd3;
  localparam logic [11:0] OCTET_MAX    = 12'd255;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

endpackage

### design/address_literal_recognizer.sv
// top level: per-character word classifier for mac, ipv6, ipv4, number and name words
// result: a word's result is loaded into the result register when its last character advances out of the input register
// throughput: one character per cycle unless a last character waits on a stalled result, words back to back with no gap
// an input register and a result register bound the single pass of word logic
// reset (synchronous, rst_n low) empties both registers and clears all word state
// the group store needs no clearing: entries not written in the current word are masked
module address_literal_recognizer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  alr_pkg::alr_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output alr_pkg::alr_out_t out_data
);
  import alr_pkg::*;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       adv;

  // result register
  logic     out_valid_r;
  alr_out_t out_data_r;
  alr_out_t res_nxt;

  // word state
  logic [4:0]  len_r, len_nxt;
  logic        sdig_r, sdig_nxt;
  logic        cseen_r, cseen_nxt;
  logic [3:0]  nl_r, nl_nxt;
  logic [3:0]  nr_r, nr_nxt;
  logic [15:0] gval_r, gval_nxt;
  logic [2:0]  gdig_r, gdig_nxt;
  logic        prev_r, prev_nxt;
  logic        pair_r, pair_nxt;
  logic        dbl_r, dbl_nxt;
  logic        emac_r, emac_nxt;
  logic        ev6_r, ev6_nxt;
  logic        ev4_r, ev4_nxt;
  logic        enum_r, enum_nxt;
  logic [31:0] oct_r, oct_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [7:0]  v4val_r, v4val_nxt;
  logic        v4dig_r, v4dig_nxt;
  logic [31:0] nval_r, nval_nxt;
  logic        novf_r, novf_nxt;

  // group stores: left groups by position, right groups shifted in from the end
  logic [15:0] grp_l_r [8];
  logic [15:0] grp_l_nxt [8];
  logic [15:0] grp_r_r [8];
  logic [15:0] grp_r_nxt [8];

  // character decode
  logic       is_dig, is_colon, is_dot, nib_ok;
  logic [3:0] nib, dval;
  logic       mac_colon_pos;

  // group push and finish helpers
  logic        push;
  logic [15:0] push_val;
  logic [3:0]  total;
  logic [11:0] v4_prod;
  logic [35:0] n_prod;
  logic        v4_ok;
  logic [15:0] grp [8];
  logic [3:0]  tail_first;

  // handshake
  assign adv       = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // character classes
  always_comb begin
    is_dig   = (s1_char_r >= CH_ZERO) && (s1_char_r <= CH_NINE);
    is_colon = (s1_char_r == CH_COLON);
    is_dot   = (s1_char_r == CH_DOT);
    dval     = s1_char_r[3:0];
    nib_ok   = 1'b1;
    if (is_dig) begin
      nib = s1_char_r[3:0];
    end else if ((s1_char_r >= CH_LA) && (s1_char_r <= CH_LF)) begin
      nib = 4'(s1_char_r - CH_LA + 8'd10);
    end else if ((s1_char_r >= CH_UA) && (s1_char_r <= CH_UF)) begin
      nib = 4'(s1_char_r - CH_UA + 8'd10);
    end else begin
      nib    = 4'd0;
      nib_ok = 1'b0;
    end
    mac_colon_pos = (len_r == 5'd2) || (len_r == 5'd5) || (len_r == 5'd8) ||
                    (len_r == 5'd11) || (len_r == 5'd14);
  end

  // one pass: character update, end of word and result
  always_comb begin
    len_nxt   = (len_r == LEN_MAX) ? len_r : len_r + 5'd1;
    sdig_nxt  = (len_r == 5'd0) ? is_dig : sdig_r;
    cseen_nxt = cseen_r | is_colon;
    nl_nxt    = nl_r;
    nr_nxt    = nr_r;
    gval_nxt  = gval_r;
    gdig_nxt  = gdig_r;
    prev_nxt  = prev_r;
    pair_nxt  = pair_r;
    dbl_nxt   = dbl_r;
    emac_nxt  = emac_r;
    ev6_nxt   = ev6_r;
    ev4_nxt   = ev4_r;
    enum_nxt  = enum_r;
    oct_nxt   = oct_r;
    idx_nxt   = idx_r;
    v4val_nxt = v4val_r;
    v4dig_nxt = v4dig_r;
    nval_nxt  = nval_r;
    novf_nxt  = novf_r;
    grp_l_nxt = grp_l_r;
    grp_r_nxt = grp_r_r;
    push      = 1'b0;
    push_val  = gval_r;

    // mac pattern: hex pairs split by colons
    if (len_r < MAC_TEXT_LEN) begin
      if (mac_colon_pos) begin
        if (!is_colon) emac_nxt = 1'b1;
      end else if (!nib_ok) begin
        emac_nxt = 1'b1;
      end
    end

    // ipv6 groups
    if (is_colon) begin
      if (prev_r) begin
        if (dbl_r) begin
          ev6_nxt = 1'b1;
        end else begin
          dbl_nxt  = 1'b1;
          pair_nxt = 1'b1;
        end
      end else begin
        if (gdig_r != 3'd0) push = 1'b1;
        pair_nxt = 1'b0;
      end
      prev_nxt = 1'b1;
    end else begin
      if (prev_r && !pair_r && (len_r == 5'd1)) ev6_nxt = 1'b1;
      if (!nib_ok) begin
        ev6_nxt = 1'b1;
      end else if (gdig_r >= GROUP_DIGITS) begin
        ev6_nxt = 1'b1;
      end else begin
        gdig_nxt = gdig_r + 3'd1;
        gval_nxt = {gval_r[11:0], nib};
      end
      prev_nxt = 1'b0;
      pair_nxt = 1'b0;
    end

    // end of word closes a trailing group
    if (s1_last_r) begin
      if (prev_nxt && !pair_nxt) ev6_nxt = 1'b1;
      if (gdig_nxt != 3'd0) begin
        push     = 1'b1;
        push_val = gval_nxt;
      end
    end

    // group push, at most one per character
    total = nl_r + nr_r;
    if (push) begin
      if (total >= GROUP_SLOTS) begin
        ev6_nxt = 1'b1;
      end else if (dbl_nxt) begin
        for (int i = 0; i < 7; i++) grp_r_nxt[i] = grp_r_r[i + 1];
        grp_r_nxt[7] = push_val;
        nr_nxt       = nr_r + 4'd1;
      end else begin
        grp_l_nxt[nl_r[2:0]] = push_val;
        nl_nxt               = nl_r + 4'd1;
      end
      gval_nxt = 16'd0;
      gdig_nxt = 3'd0;
    end

    // dotted ipv4
    v4_prod = {1'b0, v4val_r, 3'b000} + {3'b000, v4val_r, 1'b0} + {8'd0, dval};
    if (!ev4_r) begin
      if (is_dot) begin
        if (!v4dig_r || (idx_r > OCTET_LAST)) begin
          ev4_nxt = 1'b1;
        end else begin
          oct_nxt[{~idx_r[1:0], 3'b000} +: 8] = v4val_r;
          idx_nxt   = idx_r + 3'd1;
          v4val_nxt = 8'd0;
          v4dig_nxt = 1'b0;
        end
      end else if (is_dig) begin
        v4val_nxt = v4_prod[7:0];
        v4dig_nxt = 1'b1;
        if (v4_prod > OCTET_MAX) ev4_nxt = 1'b1;
      end else begin
        ev4_nxt = 1'b1;
      end
    end

    // decimal number
    n_prod = {1'b0, nval_r, 3'b000} + {3'b000, nval_r, 1'b0} + {32'd0, dval};
    if (!is_dig) begin
      enum_nxt = 1'b1;
    end else if (!novf_r) begin
      nval_nxt = n_prod[31:0];
      if (n_prod[35:32] != 4'd0) novf_nxt = 1'b1;
    end

    // assemble ipv6 groups: left part, zero fill, right part
    tail_first = GROUP_SLOTS - nr_nxt;
    for (int i = 0; i < 8; i++) begin
      grp[i] = ((4'(i) < nl_nxt) ? grp_l_nxt[i] : 16'd0) |
               ((4'(i) >= tail_first) ? grp_r_nxt[i] : 16'd0);
    end

    // three dots must close the first three octets, and the fourth octet must hold a digit
    v4_ok = !ev4_nxt && v4dig_nxt && (idx_nxt == OCTET_LAST);

    // classification
    res_nxt.kind      = KIND_INVALID;
    res_nxt.addr_high = 64'd0;
    res_nxt.addr_low  = 64'd0;
    if (cseen_nxt) begin
      if (!emac_nxt && (len_nxt == MAC_TEXT_LEN)) begin
        res_nxt.kind     = KIND_MAC;
        res_nxt.addr_low = {16'd0, grp_l_nxt[0][7:0], grp_l_nxt[1][7:0],
                            grp_l_nxt[2][7:0], grp_l_nxt[3][7:0],
                            grp_l_nxt[4][7:0], grp_l_nxt[5][7:0]};
      end else if (!ev6_nxt && ((nl_nxt + nr_nxt) <= GROUP_SLOTS) &&
                   (dbl_nxt ? ((nl_nxt + nr_nxt) <= DBL_GROUPS)
                            : ((nl_nxt + nr_nxt) == GROUP_SLOTS))) begin
        res_nxt.kind      = KIND_IPV6;
        res_nxt.addr_high = {grp[0], grp[1], grp[2], grp[3]};
        res_nxt.addr_low  = {grp[4], grp[5], grp[6], grp[7]};
      end
    end else if (sdig_nxt) begin
      if (v4_ok) begin
        res_nxt.kind     = KIND_IPV4;
        res_nxt.addr_low = {32'd0, oct_nxt[31:8], v4val_nxt};
      end else if (!enum_nxt && !novf_nxt) begin
        res_nxt.kind     = KIND_NUMBER;
        res_nxt.addr_low = {32'd0, nval_nxt};
      end
    end else begin
      res_nxt.kind = KIND_NAME;
    end

    // start a fresh word after the last character
    if (s1_last_r) begin
      len_nxt   = 5'd0;
      sdig_nxt  = 1'b0;
      cseen_nxt = 1'b0;
      nl_nxt    = 4'd0;
      nr_nxt    = 4'd0;
      gval_nxt  = 16'd0;
      gdig_nxt  = 3'd0;
      prev_nxt  = 1'b0;
      pair_nxt  = 1'b0;
      dbl_nxt   = 1'b0;
      emac_nxt  = 1'b0;
      ev6_nxt   = 1'b0;
      ev4_nxt   = 1'b0;
      enum_nxt  = 1'b0;
      oct_nxt   = 32'd0;
      idx_nxt   = 3'd0;
      v4val_nxt = 8'd0;
      v4dig_nxt = 1'b0;
      nval_nxt  = 32'd0;
      novf_nxt  = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      s1_char_r <= in_data.char_code;
      s1_last_r <= in_data.last_char;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (adv && s1_last_r) begin
      out_data_r <= res_nxt;
    end
  end

  // word state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= 5'd0;
      sdig_r  <= 1'b0;
      cseen_r <= 1'b0;
      nl_r    <= 4'd0;
      nr_r    <= 4'd0;
      gval_r  <= 16'd0;
      gdig_r  <= 3'd0;
      prev_r  <= 1'b0;
      pair_r  <= 1'b0;
      dbl_r   <= 1'b0;
      emac_r  <= 1'b0;
      ev6_r   <= 1'b0;
      ev4_r   <= 1'b0;
      enum_r  <= 1'b0;
      oct_r   <= 32'd0;
      idx_r   <= 3'd0;
      v4val_r <= 8'd0;
      v4dig_r <= 1'b0;
      nval_r  <= 32'd0;
      novf_r  <= 1'b0;
    end else if (adv) begin
      len_r   <= len_nxt;
      sdig_r  <= sdig_nxt;
      cseen_r <= cseen_nxt;
      nl_r    <= nl_nxt;
      nr_r    <= nr_nxt;
      gval_r  <= gval_nxt;
      gdig_r  <= gdig_nxt;
      prev_r  <= prev_nxt;
      pair_r  <= pair_nxt;
      dbl_r   <= dbl_nxt;
      emac_r  <= emac_nxt;
      ev6_r   <= ev6_nxt;
      ev4_r   <= ev4_nxt;
      enum_r  <= enum_nxt;
      oct_r   <= oct_nxt;
      idx_r   <= idx_nxt;
      v4val_r <= v4val_nxt;
      v4dig_r <= v4dig_nxt;
      nval_r  <= nval_nxt;
      novf_r  <= novf_nxt;
    end
  end

  // group stores, read only below the group counts
  always_ff @(posedge clk) begin
    if (adv) begin
      grp_l_r <= grp_l_nxt;
      grp_r_r <= grp_r_nxt;
    end
  end

  // checks
  a_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (nl_r + nr_r) <= GROUP_SLOTS)
    else $error("group count above eight");

  a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_last_r |=> out_valid_r)
    else $error("last character did not load a result");

  a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_last_r && out_valid_r)
    else $error("input stalled without a pending result");

  a_empty_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.kind == KIND_INVALID || out_data_r.kind == KIND_NAME)
      |-> out_data_r.addr_high == 64'd0 && out_data_r.addr_low == 64'd0)
    else $error("address bits set on an invalid or name word");

  a_high_v6_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.kind != KIND_IPV6 |-> out_data_r.addr_high == 64'd0)
    else $error("upper address bits set on a non ipv6 word");

endmodule
